FILE: rtl/sorted_class_list_core_assert.svh
// Assertion macros for the sorted class list core.
`ifndef SORTED_CLASS_LIST_CORE_ASSERT_SVH
`define SORTED_CLASS_LIST_CORE_ASSERT_SVH

// Check an implication in the same cycle.
`define SCL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scl check failed");

// Check an implication in the cycle after the antecedent.
`define SCL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scl check failed");

`endif

FILE: rtl/scl_pkg.sv
// Shared types and constants for the sorted class list core.
package scl_pkg;

  localparam int CAPACITY = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int COUNT_W  = $clog2(CAPACITY + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] arrival_minute;
    logic        is_member;
    logic [15:0] entry_id;
  } in_t;

  typedef struct packed {
    logic [5:0]  item_count;
    logic        list_empty;
    logic [15:0] head_id;
    logic [15:0] tail_id;
    logic        member_present;
    logic [15:0] first_member_id;
    logic [15:0] final_member_id;
    logic        supporter_present;
    logic [15:0] first_supporter_id;
    logic        insert_dropped;
  } out_t;

  typedef struct packed {
    logic [15:0] minute;
    logic        member;
    logic [15:0] id;
  } entry_t;

  typedef struct packed {
    logic load;
    logic clr_count;
    logic set_pos_count;
    logic set_pos_found;
    logic idx_zero;
    logic idx_count;
    logic rd_up;
    logic rd_down;
    logic wr_shift;
    logic wr_new;
    logic sum_clear;
    logic sum_acc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_clear;
    logic in_store;
    logic in_append;
    logic full;
    logic idx_at_count;
    logic idx_at_pos;
    logic rd_vld;
    logic rd_greater;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/sorted_class_list_core.sv
// Top level of the sorted class list core.
// Usage: one request on in_valid/in_ready/in_data carries op, arrival_minute,
// is_member and entry_id. Op insert places the entry before the first stored
// entry with a later minute, op append places it at the end, op clear empties
// the table; other codes leave it unchanged. Every request yields exactly one
// result on out_valid/out_ready/out_data with the count, head and tail ids,
// member and supporter ids and the dropped flag for a full table.
// Timing: a request is taken only when the controller is idle. An insert runs
// a front search, a shift of the tail one entry per cycle when it lands ahead
// of a stored entry, placement, then a summary walk; an append places the entry
// and then walks the summary; a clear and a dropped or unused request go straight
// to the summary walk. The entry memory takes one read and one write per cycle.
// The result becomes valid in the same cycle as the controller returns to idle.
// Stall: the result sits in an output register; the next request is taken
// while it waits, and the block holds in its final step until it is taken.
// Reset: synchronous, active high; empties the table and drops any result.
module sorted_class_list_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  scl_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output scl_pkg::out_t out_data
);
  import scl_pkg::*;
  `include "sorted_class_list_core_assert.svh"

  cmd_t    cmd;
  status_t st;

  scl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  scl_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  `SCL_ASSERT_NEXT(a_busy_after_req, clk, rst, in_valid && in_ready, !in_ready)
  `SCL_ASSERT_NOW(a_count_bound, clk, rst, out_valid,
                  out_data.item_count <= 6'(CAPACITY))
  `SCL_ASSERT_NOW(a_empty_flag, clk, rst, out_valid,
                  out_data.list_empty == (out_data.item_count == 6'd0))
  `SCL_ASSERT_NOW(a_drop_full, clk, rst, out_valid && out_data.insert_dropped,
                  out_data.item_count == 6'(CAPACITY))
  `SCL_ASSERT_NOW(a_one_write, clk, rst, cmd.wr_new, !cmd.wr_shift)

endmodule

FILE: rtl/scl_dpath.sv
// Datapath: entry memory, counters, summary accumulators and result register.
module scl_dpath (
  input  logic            clk,
  input  logic            rst,
  input  scl_pkg::in_t    in_data,
  input  scl_pkg::cmd_t   cmd,
  output scl_pkg::status_t st,
  input  logic            out_ready,
  output logic            out_valid,
  output scl_pkg::out_t   out_data
);
  import scl_pkg::*;

  entry_t             mem [CAPACITY];
  in_t                req;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] pos;
  logic [COUNT_W-1:0] idx;
  logic [COUNT_W-1:0] idx_dec;
  logic [COUNT_W-1:0] rd_idx;
  logic [COUNT_W-1:0] rd_idx_inc;
  entry_t             rd_data;
  logic               rd_vld;
  logic               dropped;
  logic [15:0]        head;
  logic [15:0]        tail;
  logic [15:0]        fmem;
  logic [15:0]        lmem;
  logic [15:0]        fsup;
  logic               mem_seen;
  logic               sup_seen;
  logic [ADDR_W-1:0]  wr_addr;
  entry_t             wr_entry;

  assign idx_dec    = idx - COUNT_W'(1);
  assign rd_idx_inc = rd_idx + COUNT_W'(1);

  always_comb begin
    st.in_clear     = (in_data.op == OP_CLEAR);
    st.in_store     = (in_data.op == OP_INSERT) || (in_data.op == OP_APPEND);
    st.in_append    = (in_data.op == OP_APPEND);
    st.full         = (count == COUNT_W'(CAPACITY));
    st.idx_at_count = (idx == count);
    st.idx_at_pos   = (idx == pos);
    st.rd_vld       = rd_vld;
    st.rd_greater   = rd_vld && (rd_data.minute > req.arrival_minute);
    st.out_free     = !out_valid || out_ready;
  end

  always_comb begin
    if (cmd.wr_new) begin
      wr_addr  = pos[ADDR_W-1:0];
      wr_entry = '{minute: req.arrival_minute, member: req.is_member, id: req.entry_id};
    end else begin
      wr_addr  = rd_idx_inc[ADDR_W-1:0];
      wr_entry = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_new || cmd.wr_shift) begin
      mem[wr_addr] <= wr_entry;
    end
    if (cmd.rd_up) begin
      rd_data <= mem[idx[ADDR_W-1:0]];
    end else if (cmd.rd_down) begin
      rd_data <= mem[idx_dec[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_count) begin
        count <= '0;
      end else if (cmd.wr_new) begin
        count <= count + COUNT_W'(1);
      end
      rd_vld <= cmd.rd_up || cmd.rd_down;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req     <= in_data;
      dropped <= st.in_store && st.full;
    end
    if (cmd.set_pos_count) begin
      pos <= count;
    end else if (cmd.set_pos_found) begin
      pos <= rd_idx;
    end
    if (cmd.idx_zero) begin
      idx <= '0;
    end else if (cmd.idx_count) begin
      idx <= count;
    end else if (cmd.rd_up) begin
      idx <= idx + COUNT_W'(1);
    end else if (cmd.rd_down) begin
      idx <= idx_dec;
    end
    if (cmd.rd_up) begin
      rd_idx <= idx;
    end else if (cmd.rd_down) begin
      rd_idx <= idx_dec;
    end
    if (cmd.sum_clear) begin
      head     <= '0;
      tail     <= '0;
      fmem     <= '0;
      lmem     <= '0;
      fsup     <= '0;
      mem_seen <= 1'b0;
      sup_seen <= 1'b0;
    end else if (cmd.sum_acc) begin
      if (rd_idx == '0) begin
        head <= rd_data.id;
      end
      tail <= rd_data.id;
      if (rd_data.member) begin
        if (!mem_seen) begin
          fmem <= rd_data.id;
        end
        lmem     <= rd_data.id;
        mem_seen <= 1'b1;
      end else if (!sup_seen) begin
        fsup     <= rd_data.id;
        sup_seen <= 1'b1;
      end
    end
    if (cmd.out_load) begin
      out_data.item_count         <= 6'(count);
      out_data.list_empty         <= (count == '0);
      out_data.head_id            <= head;
      out_data.tail_id            <= tail;
      out_data.member_present     <= mem_seen;
      out_data.first_member_id    <= fmem;
      out_data.final_member_id    <= lmem;
      out_data.supporter_present  <= sup_seen;
      out_data.first_supporter_id <= fsup;
      out_data.insert_dropped     <= dropped;
    end
  end

endmodule

FILE: rtl/scl_ctrl.sv
// Controller: sequences search, shift, placement and summary walk per request.
module scl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  scl_pkg::status_t st,
  output scl_pkg::cmd_t    cmd
);
  import scl_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEARCH = 6'b000010,
    S_SHIFT  = 6'b000100,
    S_PLACE  = 6'b001000,
    S_SUM    = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load      = 1'b1;
          cmd.idx_zero  = 1'b1;
          cmd.sum_clear = 1'b1;
          if (st.in_clear) begin
            cmd.clr_count = 1'b1;
            state_next    = S_SUM;
          end else if (st.in_store && !st.full) begin
            if (st.in_append) begin
              cmd.set_pos_count = 1'b1;
              state_next        = S_PLACE;
            end else begin
              state_next = S_SEARCH;
            end
          end else begin
            state_next = S_SUM;
          end
        end
      end
      S_SEARCH: begin
        if (st.rd_greater) begin
          cmd.set_pos_found = 1'b1;
          cmd.idx_count     = 1'b1;
          state_next        = S_SHIFT;
        end else if (st.idx_at_count && !st.rd_vld) begin
          cmd.set_pos_count = 1'b1;
          state_next        = S_PLACE;
        end else if (!st.idx_at_count) begin
          cmd.rd_up = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd.wr_shift = st.rd_vld;
        if (!st.idx_at_pos) begin
          cmd.rd_down = 1'b1;
        end else if (!st.rd_vld) begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.wr_new    = 1'b1;
        cmd.idx_zero  = 1'b1;
        cmd.sum_clear = 1'b1;
        state_next    = S_SUM;
      end
      S_SUM: begin
        cmd.sum_acc = st.rd_vld;
        if (!st.idx_at_count) begin
          cmd.rd_up = 1'b1;
        end else if (!st.rd_vld) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: verif/sorted_class_list_core_tb.sv
// Self-checking testbench for the sorted class list core: directed, full-table, stall, steady-stream and random.
module sorted_class_list_core_tb;
  import scl_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_PCT = 32;
  localparam int STALL_LIMIT = 6000;
  localparam int SETTLE_CYCLES = 200;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  entry_t roster [CAPACITY];
  int roster_len;
  out_t pending_summaries [$];

  bit no_idle;
  int rx_hold_left;
  int error_count;
  int stall_cycles;
  int results_seen;
  int n_insert, n_append, n_clear, n_unused, n_dropped, peak_len;

  sorted_class_list_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #2 clk = ~clk;

  function automatic in_t make_request(logic [1:0] op, logic [15:0] minute, logic member,
                                       logic [15:0] id);
    in_t req;
    req.op = op;
    req.arrival_minute = minute;
    req.is_member = member;
    req.entry_id = id;
    return req;
  endfunction

  function automatic out_t apply_and_summarize(in_t req);
    out_t res;
    int k;
    int pos;
    bit found;
    bit mem_seen;
    bit sup_seen;
    res = '0;
    found = 0;
    mem_seen = 0;
    sup_seen = 0;
    if (req.op == OP_INSERT || req.op == OP_APPEND) begin
      if (roster_len >= CAPACITY) begin
        res.insert_dropped = 1'b1;
        n_dropped++;
      end else begin
        pos = roster_len;
        if (req.op == OP_INSERT) begin
          for (k = 0; k < roster_len; k++) begin
            if (!found && roster[k].minute > req.arrival_minute) begin
              pos = k;
              found = 1;
            end
          end
        end
        for (k = roster_len; k > pos; k--) roster[k] = roster[k - 1];
        roster[pos].minute = req.arrival_minute;
        roster[pos].member = req.is_member;
        roster[pos].id = req.entry_id;
        roster_len++;
      end
      if (req.op == OP_INSERT) n_insert++;
      else n_append++;
    end else if (req.op == OP_CLEAR) begin
      roster_len = 0;
      n_clear++;
    end else begin
      n_unused++;
    end
    if (roster_len > peak_len) peak_len = roster_len;

    res.item_count = roster_len[5:0];
    res.list_empty = (roster_len == 0);
    if (roster_len > 0) begin
      res.head_id = roster[0].id;
      res.tail_id = roster[roster_len - 1].id;
    end
    for (k = 0; k < roster_len; k++) begin
      if (roster[k].member) begin
        if (!mem_seen) res.first_member_id = roster[k].id;
        res.final_member_id = roster[k].id;
        mem_seen = 1;
      end else if (!sup_seen) begin
        res.first_supporter_id = roster[k].id;
        sup_seen = 1;
      end
    end
    res.member_present = mem_seen;
    res.supporter_present = sup_seen;
    return res;
  endfunction

  function automatic logic [15:0] rand_minute();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'h0000;
    if (pick == 1) return 16'hFFFF;
    if (pick < 6) return 16'($urandom_range(0, 31));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] rand_id();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 16'h0000;
    if (pick == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic in_t rand_request(int insert_pct, int append_pct, int unused_pct);
    int r;
    logic [1:0] op;
    r = $urandom_range(0, 99);
    if (r < insert_pct) op = OP_INSERT;
    else if (r < insert_pct + append_pct) op = OP_APPEND;
    else if (r < insert_pct + append_pct + unused_pct) op = OP_UNUSED;
    else op = OP_CLEAR;
    return make_request(op, rand_minute(), 1'($urandom), rand_id());
  endfunction

  task automatic send_request(in_t req);
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    pending_summaries.push_back(apply_and_summarize(req));
  endtask

  task automatic release_bus();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_for_drain();
    while (pending_summaries.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_request(make_request(OP_UNUSED, 16'h1234, 1'b1, 16'h4321));
    send_request(make_request(OP_CLEAR, 16'h0000, 1'b0, 16'h0000));
    send_request(make_request(OP_INSERT, 16'd100, 1'b1, 16'h0001));
    send_request(make_request(OP_INSERT, 16'd100, 1'b0, 16'h0002));
    send_request(make_request(OP_INSERT, 16'h0000, 1'b1, 16'h0000));
    send_request(make_request(OP_INSERT, 16'hFFFF, 1'b0, 16'hFFFF));
    send_request(make_request(OP_INSERT, 16'd100, 1'b1, 16'h0003));
    send_request(make_request(OP_APPEND, 16'h0000, 1'b1, 16'h0004));
    send_request(make_request(OP_INSERT, 16'd50, 1'b0, 16'h0005));
    send_request(make_request(OP_UNUSED, 16'hFFFF, 1'b0, 16'hFFFF));
    send_request(make_request(OP_CLEAR, 16'hFFFF, 1'b1, 16'hFFFF));
    send_request(make_request(OP_APPEND, 16'hFFFF, 1'b1, 16'hFFFF));
    send_request(make_request(OP_INSERT, 16'hFFFF, 1'b1, 16'h00AA));
    send_request(make_request(OP_INSERT, 16'hFFFE, 1'b1, 16'h00BB));
    send_request(make_request(OP_CLEAR, 16'h0000, 1'b0, 16'h0000));
    send_request(make_request(OP_APPEND, 16'h8000, 1'b0, 16'hA5A5));
    send_request(make_request(OP_INSERT, 16'h8000, 1'b0, 16'h5A5A));
    send_request(make_request(OP_CLEAR, 16'h0000, 1'b0, 16'h0000));
  endtask

  task automatic test_full_table();
    int k;
    send_request(make_request(OP_CLEAR, 16'h0000, 1'b0, 16'h0000));
    for (k = 0; k < CAPACITY; k++) send_request(rand_request(60, 40, 0));
    send_request(make_request(OP_INSERT, 16'h0000, 1'b1, 16'hDEAD));
    send_request(make_request(OP_APPEND, 16'hFFFF, 1'b0, 16'hBEEF));
    send_request(make_request(OP_UNUSED, 16'h0000, 1'b1, 16'h1111));
    send_request(make_request(OP_INSERT, 16'h7FFF, 1'b0, 16'h2222));
    send_request(make_request(OP_CLEAR, 16'h0000, 1'b0, 16'h0000));
  endtask

  task automatic test_output_stall();
    int k;
    no_idle = 1;
    rx_hold_left = 400;
    for (k = 0; k < 12; k++) send_request(rand_request(70, 25, 0));
    no_idle = 0;
    release_bus();
    wait_for_drain();
  endtask

  task automatic test_steady_stream();
    int k;
    no_idle = 1;
    for (k = 0; k < 100; k++) send_request(rand_request(65, 25, 3));
    no_idle = 0;
  endtask

  task automatic test_random(int quota);
    int sent;
    int target;
    int k;
    in_t req;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(0, 3) == 0) begin
        send_request(make_request(OP_CLEAR, rand_minute(), 1'($urandom), rand_id()));
        sent++;
      end
      if ($urandom_range(0, 4) == 0) target = $urandom_range(30, 40);
      else target = $urandom_range(1, 20);
      for (k = 0; k < target; k++) begin
        req = rand_request(65, 25, 5);
        send_request(req);
        if (req.op != OP_UNUSED) sent++;
      end
      if ($urandom_range(0, 9) == 0) begin
        release_bus();
        wait_for_drain();
      end
    end
  endtask

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_summaries.size() == 0) begin
        $error("result with no request outstanding");
        error_count++;
      end else begin
        want = pending_summaries.pop_front();
        compare_field("item_count", 16'(want.item_count), 16'(out_data.item_count));
        compare_field("list_empty", 16'(want.list_empty), 16'(out_data.list_empty));
        compare_field("head_id", want.head_id, out_data.head_id);
        compare_field("tail_id", want.tail_id, out_data.tail_id);
        compare_field("member_present", 16'(want.member_present),
                      16'(out_data.member_present));
        compare_field("first_member_id", want.first_member_id, out_data.first_member_id);
        compare_field("final_member_id", want.final_member_id, out_data.final_member_id);
        compare_field("supporter_present", 16'(want.supporter_present),
                      16'(out_data.supporter_present));
        compare_field("first_supporter_id", want.first_supporter_id,
                      out_data.first_supporter_id);
        compare_field("insert_dropped", 16'(want.insert_dropped),
                      16'(out_data.insert_dropped));
      end
    end
  end

  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      out_ready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    no_idle = 0;
    rx_hold_left = 0;
    error_count = 0;
    stall_cycles = 0;
    results_seen = 0;
    roster_len = 0;
    n_insert = 0;
    n_append = 0;
    n_clear = 0;
    n_unused = 0;
    n_dropped = 0;
    peak_len = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_full_table();
    test_output_stall();
    test_steady_stream();
    test_random(1080);

    release_bus();
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d inserts, %0d appends, %0d clears, %0d unused ops; %0d results",
             n_insert, n_append, n_clear, n_unused, results_seen);
    $display("peak fill %0d of %0d entries, %0d requests dropped on a full table",
             peak_len, CAPACITY, n_dropped);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
